### hdl/assert_macros.svh
// Assertion macros for the glob star name matcher RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### hdl/gsnm_pkg.sv
// Package for the glob star name matcher: request/result types, commands,
// character constants and default sizing. No dependencies.
`timescale 1ns / 1ps

package gsnm_pkg;

	localparam int GSNM_MAX_PATTERN = 32;

	localparam logic [7:0] STAR_CHAR = 8'h2A;
	localparam logic [7:0] DOT_CHAR  = 8'h2E;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_BYTE   = 2'd2,
		CMD_END    = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] symbol;
		logic       wild_star;
	} req_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} res_t;

	// pattern store control, one request per cycle
	typedef struct packed {
		logic       clear;
		logic       append;
		logic [7:0] symbol;
		logic       wild_star;
	} store_ctl_t;

endpackage

### hdl/gsnm_pattern_store.sv
// Pattern symbol/flag storage with length and overflow tracking.
// Produces per-position wildcard and byte-hit vectors. Depends on gsnm_pkg.
`timescale 1ns / 1ps

module gsnm_pattern_store #(
	parameter int MAX_PATTERN = gsnm_pkg::GSNM_MAX_PATTERN,
	localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gsnm_pkg::store_ctl_t     ctl,
	output logic [LEN_W-1:0]         length,
	output logic                     full,
	output logic                     overflow,
	output logic [MAX_PATTERN-1:0]   wild_vec,
	output logic [MAX_PATTERN-1:0]   hit_vec
);

	logic [LEN_W-1:0] length_q;
	logic             overflow_q;
	logic [7:0]       sym_q  [MAX_PATTERN];
	logic             wild_q [MAX_PATTERN];

	assign full     = (length_q == LEN_W'(MAX_PATTERN));
	assign length   = length_q;
	assign overflow = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q   <= '0;
			overflow_q <= 1'b0;
		end else if (ctl.clear) begin
			length_q   <= '0;
			overflow_q <= 1'b0;
		end else if (ctl.append) begin
			if (full) begin
				overflow_q <= 1'b1;
			end else begin
				length_q <= length_q + LEN_W'(1);
			end
		end
	end

	for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_entry
		always_ff @(posedge clk) begin
			if (ctl.append && !full && (length_q == LEN_W'(p))) begin
				sym_q[p]  <= ctl.symbol;
				wild_q[p] <= (ctl.symbol == gsnm_pkg::STAR_CHAR) && ctl.wild_star;
			end
		end

		always_comb begin
			logic in_range;
			in_range    = (LEN_W'(p) < length_q);
			wild_vec[p] = in_range && wild_q[p];
			hit_vec[p]  = in_range && !wild_q[p] && (sym_q[p] == ctl.symbol);
		end
	end

endmodule

### hdl/gsnm_closure.sv
// Empty-match closure over the position set: a position reached through a
// run of live wildcards is set too. Log-depth prefix scan. Depends on gsnm_pkg.
`timescale 1ns / 1ps

module gsnm_closure #(
	parameter int WIDTH = gsnm_pkg::GSNM_MAX_PATTERN + 1,
	localparam int LEVELS = $clog2(WIDTH)
) (
	input  logic [WIDTH-1:0] set_in,
	input  logic [WIDTH-1:0] link,     // link[k]: k reachable from k-1
	output logic [WIDTH-1:0] set_out
);

	always_comb begin
		logic [WIDTH-1:0] x;
		logic [WIDTH-1:0] t;
		x = set_in;
		t = link;
		for (int l = 0; l < LEVELS; l++) begin
			x = x | (t & (x << (1 << l)));
			t = t & (t << (1 << l));
		end
		set_out = x;
	end

endmodule

### hdl/glob_star_name_matcher_core.sv
// Glob star name matcher, top level. Depends on gsnm_pkg, gsnm_pattern_store,
// gsnm_closure and assert_macros.svh.
// Timing: a request is registered in the input register at acceptance; an
// end-of-name result then goes to the result register. One request per cycle
// unless an end request is held by a stalled result; each byte advances the whole position set.
// Reset: async, clears pattern length, overflow and name state.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glob_star_name_matcher_core #(
	parameter int MAX_PATTERN = gsnm_pkg::GSNM_MAX_PATTERN
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  gsnm_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_stall,
	output gsnm_pkg::res_t res
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam logic [MAX_PATTERN:0] POS_START = (MAX_PATTERN + 1)'(1);

	logic                   valid_s1;
	gsnm_pkg::req_t         req_s1;
	logic                   s1_go;
	logic                   fire;
	logic                   end_fire;

	logic [MAX_PATTERN:0]   live_q, live_d;
	logic [MAX_PATTERN:0]   start_q, start_d;
	logic                   at_start_q, at_start_d;
	logic                   hidden_q, hidden_d;

	logic                   res_valid_q;
	gsnm_pkg::res_t         res_q;

	gsnm_pkg::store_ctl_t   store_ctl;
	logic [LEN_W-1:0]       length;
	logic                   full;
	logic                   overflow;
	logic [MAX_PATTERN-1:0] wild_vec;
	logic [MAX_PATTERN-1:0] hit_vec;

	logic [MAX_PATTERN:0]   raw_next;
	logic [MAX_PATTERN:0]   closed_next;
	logic                   app_wild;
	logic [MAX_PATTERN:0]   live_mask;

	// input register
	assign s1_go     = !((req_s1.command == gsnm_pkg::CMD_END) && res_valid_q && res_stall);
	assign req_stall = valid_s1 && !s1_go;
	assign fire      = valid_s1 && s1_go;
	assign end_fire  = fire && (req_s1.command == gsnm_pkg::CMD_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	assign store_ctl.clear     = fire && (req_s1.command == gsnm_pkg::CMD_CLEAR);
	assign store_ctl.append    = fire && (req_s1.command == gsnm_pkg::CMD_APPEND);
	assign store_ctl.symbol    = req_s1.symbol;
	assign store_ctl.wild_star = req_s1.wild_star;

	gsnm_pattern_store #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (store_ctl),
		.length   (length),
		.full     (full),
		.overflow (overflow),
		.wild_vec (wild_vec),
		.hit_vec  (hit_vec)
	);

	// one byte step over the closed live set, then re-close
	assign raw_next = (live_q & {1'b0, wild_vec}) | {live_q[MAX_PATTERN-1:0] & hit_vec, 1'b0};

	gsnm_closure #(
		.WIDTH (MAX_PATTERN + 1)
	) u_closure (
		.set_in  (raw_next),
		.link    ({wild_vec, 1'b0}),
		.set_out (closed_next)
	);

	assign app_wild = store_ctl.append && !full &&
		(req_s1.symbol == gsnm_pkg::STAR_CHAR) && req_s1.wild_star;

	always_comb begin
		live_d     = live_q;
		start_d    = start_q;
		at_start_d = at_start_q;
		hidden_d   = hidden_q;
		if (fire) begin
			case (req_s1.command)
				gsnm_pkg::CMD_CLEAR: begin
					live_d     = POS_START;
					start_d    = POS_START;
					at_start_d = 1'b1;
					hidden_d   = 1'b0;
				end
				gsnm_pkg::CMD_APPEND: begin
					// new trailing wildcard extends both closed sets by one
					for (int k = 1; k <= MAX_PATTERN; k++) begin
						if (app_wild && (LEN_W'(k - 1) == length)) begin
							live_d[k]  = live_q[k] | live_q[k-1];
							start_d[k] = start_q[k] | start_q[k-1];
						end
					end
				end
				gsnm_pkg::CMD_BYTE: begin
					hidden_d   = hidden_q || (at_start_q && (req_s1.symbol == gsnm_pkg::DOT_CHAR));
					at_start_d = 1'b0;
					live_d     = closed_next;
				end
				gsnm_pkg::CMD_END: begin
					live_d     = start_q;
					at_start_d = 1'b1;
					hidden_d   = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q     <= POS_START;
			start_q    <= POS_START;
			at_start_q <= 1'b1;
			hidden_q   <= 1'b0;
		end else begin
			live_q     <= live_d;
			start_q    <= start_d;
			at_start_q <= at_start_d;
			hidden_q   <= hidden_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (end_fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_fire) begin
			res_q.matched          <= !hidden_q && live_q[length];
			res_q.pattern_overflow <= overflow;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		for (int k = 0; k <= MAX_PATTERN; k++) begin
			live_mask[k] = (LEN_W'(k) <= length);
		end
	end

	`ASSERT_ALWAYS(a_live_in_pattern, clk, arst_n, (live_q & ~live_mask) == '0, "live past length")
	`ASSERT_ALWAYS(a_start_in_pattern, clk, arst_n, (start_q & ~live_mask) == '0, "start past length")
	`ASSERT_ALWAYS(a_start_bit, clk, arst_n, start_q[0], "start set lost position zero")
	`ASSERT_ALWAYS(a_hidden_after_start, clk, arst_n, !hidden_q || !at_start_q, "hidden at name start")
	`ASSERT_NEXT(a_end_gives_result, clk, arst_n, end_fire, res_valid_q, "end of name without result")

endmodule
